/* rtl/wie_pkg.sv */
// Package for the WPA information element parser: item and result types,
// status codes, byte positions and OUI constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package wie_pkg;

  localparam int BYTE_W    = 8;
  localparam int POS_W     = 9;
  localparam int VER_W     = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int NEED_W    = 19;   // 14 + 4 * 65535 fits

  typedef enum logic [2:0] {
    ST_OK,
    ST_BAD_ID,
    ST_BAD_OUI,
    ST_VER_HIGH,
    ST_SHORT,
    ST_PW_OVERRUN,
    ST_AKM_OVERRUN,
    ST_TRUNC
  } status_t;

  // register word indexes
  localparam logic REG_MAX_VERSION = 1'b0;
  localparam logic [VER_W-1:0] MAX_VERSION_RST = 16'd1;

  // fixed byte positions in the element
  localparam logic [POS_W-1:0] POS_EID    = 9'd0;
  localparam logic [POS_W-1:0] POS_LEN    = 9'd1;
  localparam logic [POS_W-1:0] POS_OUI0   = 9'd2;
  localparam logic [POS_W-1:0] POS_OUI2   = 9'd4;
  localparam logic [POS_W-1:0] POS_TYPE   = 9'd5;
  localparam logic [POS_W-1:0] POS_VER_LO = 9'd6;
  localparam logic [POS_W-1:0] POS_VER_HI = 9'd7;
  localparam logic [POS_W-1:0] POS_PW_LO  = 9'd12;
  localparam logic [POS_W-1:0] POS_PW_HI  = 9'd13;
  localparam logic [POS_W-1:0] POS_MAX    = 9'd511;

  localparam logic [BYTE_W-1:0] WPA_EID   = 8'hdd;
  localparam logic [BYTE_W-1:0] WPA_TYPE  = 8'h01;
  localparam logic [BYTE_W-1:0] AKM_DOT1X = 8'h01;
  localparam logic [BYTE_W-1:0] AKM_PSK   = 8'h02;
  localparam logic [BYTE_W-1:0] MIN_LEN   = 8'd10;

  localparam logic [NEED_W-1:0] PW_BASE  = 19'd12;
  localparam logic [NEED_W-1:0] AKM_BASE = 19'd14;

  typedef struct packed {
    logic [BYTE_W-1:0] ie_byte;
    logic              last_byte;
  } item_t;

  typedef struct packed {
    status_t           status;
    logic              auth_dot1x;
    logic              psk_offered;
    logic [BYTE_W-1:0] declared_length;
  } result_t;

  // 00-50-F2, indexed by offset within a suite
  function automatic logic [BYTE_W-1:0] oui_byte(input logic [1:0] off);
    logic [BYTE_W-1:0] v;
    case (off)
      2'd0:    v = 8'h00;
      2'd1:    v = 8'h50;
      2'd2:    v = 8'hf2;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage : wie_pkg
`default_nettype wire

/* rtl/wie_if.sv */
// Valid/ready channel interfaces for element bytes and parse results.
// Depends on wie_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface wie_in_if;
  logic                      valid;
  logic                      ready;
  logic [wie_pkg::BYTE_W-1:0] ie_byte;
  logic                      last_byte;

  modport source (output valid, output ie_byte, output last_byte, input ready);
  modport sink   (input valid, input ie_byte, input last_byte, output ready);
endinterface : wie_in_if

interface wie_out_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                status;
  logic                      auth_dot1x;
  logic                      psk_offered;
  logic [wie_pkg::BYTE_W-1:0] declared_length;

  modport source (output valid, output status, output auth_dot1x, output psk_offered,
                  output declared_length, input ready);
  modport sink   (input valid, input status, input auth_dot1x, input psk_offered,
                  input declared_length, output ready);
endinterface : wie_out_if
`default_nettype wire

/* rtl/wpa_ie_auth_type_parser.sv */
// Top level of the WPA information element parser.
// Depends on wie_pkg, wie_if, wie_cfg_regs, wie_in_stage, wie_parse_core, wie_out_stage.
//
//  port group  | dir | handshake           | carries
//  ------------+-----+---------------------+--------------------------------------
//  in_chan     | in  | valid/ready         | ie_byte, last_byte (one byte each)
//  out_chan    | out | valid/ready         | status, auth_dot1x, psk_offered, length
//  psel..      | in  | APB write/read      | max_version at byte address 0
//
// One byte per cycle while the result side has space for a last byte. A byte is
// registered in the input register, then the parser consumes it; for a last byte the
// verdict is loaded into the result register at that same edge, which raises out valid.
// Only a last byte waits for result space; other bytes flow while a result
// stalls. Reset is synchronous: parser state clears, max_version goes to 1.
`timescale 1ns / 1ps
`default_nettype none
module wpa_ie_auth_type_parser (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  wie_in_if.sink                              in_chan,
  wie_out_if.source                           out_chan,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [wie_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [wie_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [wie_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready
);
  import wie_pkg::*;

  logic             take;
  logic             hold_valid;
  item_t            in_item;
  item_t            hold_item;
  logic             res_load;
  result_t          res_core;
  result_t          res_out;
  logic             out_free;
  logic [VER_W-1:0] max_version;

  assign in_item.ie_byte   = in_chan.ie_byte;
  assign in_item.last_byte = in_chan.last_byte;

  wie_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .max_version(max_version)
  );

  // byte register in front of the parser
  wie_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_item   (in_item),
    .take      (take),
    .hold_valid(hold_valid),
    .hold_item (hold_item)
  );

  // per-element state; issues a result on the last byte
  wie_parse_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .hold_valid (hold_valid),
    .hold_item  (hold_item),
    .out_free   (out_free),
    .max_version(max_version),
    .take       (take),
    .res_load   (res_load),
    .result     (res_core)
  );

  // result register; decouples the consumer's ready from the byte stream
  wie_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (res_load),
    .res_in   (res_core),
    .out_free (out_free),
    .out_valid(out_chan.valid),
    .out_ready(out_chan.ready),
    .res_out  (res_out)
  );

  assign out_chan.status          = res_out.status;
  assign out_chan.auth_dot1x      = res_out.auth_dot1x;
  assign out_chan.psk_offered     = res_out.psk_offered;
  assign out_chan.declared_length = res_out.declared_length;
endmodule : wpa_ie_auth_type_parser
`default_nettype wire

/* rtl/wie_cfg_regs.sv */
// APB-style register port holding max_version.
// Depends on wie_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wie_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [wie_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [wie_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [wie_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready,
  output logic      [wie_pkg::VER_W-1:0]      max_version
);
  import wie_pkg::*;

  logic [VER_W-1:0] max_version_r;
  logic             hit;

  assign pready = 1'b1;
  assign hit    = (paddr[CFG_ADDR_W-1] == REG_MAX_VERSION);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_version_r <= MAX_VERSION_RST;
    end else if (psel && penable && pwrite && pready && hit) begin
      max_version_r <= pwdata[VER_W-1:0];
    end
  end

  assign prdata      = hit ? {{(CFG_DATA_W-VER_W){1'b0}}, max_version_r} : '0;
  assign max_version = max_version_r;
endmodule : wie_cfg_regs
`default_nettype wire

/* rtl/wie_in_stage.sv */
// Input register for element bytes; refills in the cycle it drains.
// Depends on wie_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wie_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire wie_pkg::item_t in_item,
  input  wire logic           take,
  output logic                hold_valid,
  output wie_pkg::item_t      hold_item
);
  import wie_pkg::*;

  logic  valid_r;
  item_t item_r;

  assign in_ready = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign hold_valid = valid_r;
  assign hold_item  = item_r;
endmodule : wie_in_stage
`default_nettype wire

/* rtl/wie_parse_core.sv */
// Per-byte parser state: position, length, verdict, AKM suite tracking.
// Depends on wie_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wie_parse_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      hold_valid,
  input  wire wie_pkg::item_t            hold_item,
  input  wire logic                      out_free,
  input  wire logic [wie_pkg::VER_W-1:0] max_version,
  output logic                           take,
  output logic                           res_load,
  output wie_pkg::result_t               result
);
  import wie_pkg::*;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] len_r, len_nxt;
  status_t           code_r, code_nxt;
  logic              fixed_r, fixed_nxt;
  logic [BYTE_W-1:0] low_r, low_nxt;
  logic              suite_ok_r, suite_ok_nxt;
  logic [1:0]        flags_r, flags_nxt;    // bit 0 802.1X, bit 1 PSK
  logic [POS_W-1:0]  akm_base_r, akm_base_nxt;
  logic [POS_W-1:0]  akm_end_r, akm_end_nxt;
  logic              suites_r, suites_nxt;
  logic [1:0]        off_r, off_nxt;

  logic [BYTE_W-1:0] b;
  logic [VER_W-1:0]  cnt;
  logic [NEED_W-1:0] cnt_x4, len_w, pw_need_lo, pw_need_hi, akm_need, akm_last;
  status_t           st;

  assign take = hold_valid && (!hold_item.last_byte || out_free);
  assign b    = hold_item.ie_byte;
  assign cnt  = {b, low_r};

  assign cnt_x4     = {1'b0, cnt, 2'b00};
  assign len_w      = {{(NEED_W-BYTE_W){1'b0}}, len_r};
  assign pw_need_lo = PW_BASE + cnt_x4;
  assign pw_need_hi = AKM_BASE + cnt_x4;
  assign akm_need   = {{(NEED_W-POS_W){1'b0}}, akm_base_r} + cnt_x4;
  assign akm_last   = akm_need + NEED_W'(1);

  always_comb begin
    pos_nxt      = pos_r;
    len_nxt      = len_r;
    code_nxt     = code_r;
    fixed_nxt    = fixed_r;
    low_nxt      = low_r;
    suite_ok_nxt = suite_ok_r;
    flags_nxt    = flags_r;
    akm_base_nxt = akm_base_r;
    akm_end_nxt  = akm_end_r;
    suites_nxt   = suites_r;
    off_nxt      = off_r;
    st           = ST_TRUNC;
    res_load     = 1'b0;
    result       = '0;

    if (take) begin
      if (!fixed_r) begin
        if (pos_r == POS_EID) begin
          if (b != WPA_EID) begin
            code_nxt  = ST_BAD_ID;
            fixed_nxt = 1'b1;
          end
        end else if (pos_r == POS_LEN) begin
          len_nxt = b;
        end else if (pos_r inside {[POS_OUI0:POS_OUI2]}) begin
          if (b != oui_byte(2'(pos_r - POS_OUI0))) suite_ok_nxt = 1'b0;
        end else if (pos_r == POS_TYPE) begin
          if (!suite_ok_r || b != WPA_TYPE) begin
            code_nxt  = ST_BAD_OUI;
            fixed_nxt = 1'b1;
          end
          suite_ok_nxt = 1'b1;
        end else if (pos_r inside {POS_VER_LO, POS_PW_LO}) begin
          low_nxt = b;
        end else if (pos_r == POS_VER_HI) begin
          if (cnt > max_version) begin
            code_nxt  = ST_VER_HIGH;
            fixed_nxt = 1'b1;
          end else if (len_r <= MIN_LEN) begin
            code_nxt  = ST_SHORT;
            fixed_nxt = 1'b1;
          end
        end else if (pos_r == POS_PW_HI) begin
          if (cnt != '0 && len_w < pw_need_lo) begin
            code_nxt  = ST_PW_OVERRUN;
            fixed_nxt = 1'b1;
          end else if (len_w < pw_need_hi) begin
            // AKM count absent: 802.1X assumed
            flags_nxt = 2'b01;
            code_nxt  = ST_OK;
            fixed_nxt = 1'b1;
          end else begin
            akm_base_nxt = pw_need_hi[POS_W-1:0];  // fits: bounded by length
          end
        end else if (pos_r > POS_PW_HI) begin
          if (pos_r == akm_base_r) begin
            low_nxt = b;
          end else if (pos_r == akm_base_r + POS_W'(1)) begin
            if (cnt != '0 && len_w < akm_need) begin
              code_nxt  = ST_AKM_OVERRUN;
              fixed_nxt = 1'b1;
            end else if (cnt == '0) begin
              code_nxt  = ST_OK;
              fixed_nxt = 1'b1;
            end else begin
              akm_end_nxt = akm_last[POS_W-1:0];
              suites_nxt  = 1'b1;
              off_nxt     = 2'd0;
            end
          end else if (suites_r) begin
            off_nxt = off_r + 2'd1;
            if (off_r != 2'd3) begin
              if (b != oui_byte(off_r)) suite_ok_nxt = 1'b0;
            end else begin
              if (suite_ok_r) begin
                if (b == AKM_DOT1X)    flags_nxt = flags_r | 2'b01;
                else if (b == AKM_PSK) flags_nxt = flags_r | 2'b10;
              end
              suite_ok_nxt = 1'b1;
              if (pos_r == akm_end_r) begin
                code_nxt  = ST_OK;
                fixed_nxt = 1'b1;
              end
            end
          end
        end
      end

      if (pos_r != POS_MAX) pos_nxt = pos_r + POS_W'(1);

      if (hold_item.last_byte) begin
        st       = fixed_nxt ? code_nxt : ST_TRUNC;
        res_load = 1'b1;
        result.status          = st;
        result.auth_dot1x      = (st == ST_OK) && flags_nxt[0];
        result.psk_offered     = (st == ST_OK) && flags_nxt[1];
        result.declared_length = len_nxt;
        pos_nxt      = '0;
        len_nxt      = '0;
        code_nxt     = ST_OK;
        fixed_nxt    = 1'b0;
        low_nxt      = '0;
        suite_ok_nxt = 1'b1;
        flags_nxt    = '0;
        suites_nxt   = 1'b0;
        off_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      len_r      <= '0;
      code_r     <= ST_OK;
      fixed_r    <= 1'b0;
      low_r      <= '0;
      suite_ok_r <= 1'b1;
      flags_r    <= '0;
      suites_r   <= 1'b0;
      off_r      <= '0;
    end else begin
      pos_r      <= pos_nxt;
      len_r      <= len_nxt;
      code_r     <= code_nxt;
      fixed_r    <= fixed_nxt;
      low_r      <= low_nxt;
      suite_ok_r <= suite_ok_nxt;
      flags_r    <= flags_nxt;
      suites_r   <= suites_nxt;
      off_r      <= off_nxt;
    end
  end

  // suite bounds: only read after being written for the current element
  always_ff @(posedge clk) begin
    akm_base_r <= akm_base_nxt;
    akm_end_r  <= akm_end_nxt;
  end
endmodule : wie_parse_core
`default_nettype wire

/* rtl/wie_out_stage.sv */
// Result register; holds a verdict until the consumer takes it.
// Depends on wie_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wie_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire wie_pkg::result_t res_in,
  output logic                  out_free,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output wie_pkg::result_t      res_out
);
  import wie_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign out_free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && out_free) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;
endmodule : wie_out_stage
`default_nettype wire

/* rtl/wie_checker.sv */
// Port-level checks for the WPA information element parser, bound to the top.
// Depends on wie_pkg and wpa_ie_auth_type_parser.
`timescale 1ns / 1ps
`default_nettype none
module wie_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       out_valid,
  input  wire logic                       out_ready,
  input  wire logic [2:0]                 status,
  input  wire logic                       auth_dot1x,
  input  wire logic                       psk_offered,
  input  wire logic [wie_pkg::BYTE_W-1:0] declared_length
);
  import wie_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(auth_dot1x)
      && $stable(psk_offered) && $stable(declared_length))
    else $error("result changed while stalled");

  // flags only accompany an accepted element
  a_flags_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_OK |-> !auth_dot1x && !psk_offered)
    else $error("auth flags set on a failed element");

  // any verdict past the length check implies a length above ten
  a_len_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_OK || status == ST_PW_OVERRUN || status == ST_AKM_OVERRUN)
      |-> declared_length > MIN_LEN)
    else $error("verdict inconsistent with declared length");

  // nothing leaves the result register straight after reset
  a_rst_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");
endmodule : wie_checker

bind wpa_ie_auth_type_parser wie_checker u_wie_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .status         (out_chan.status),
  .auth_dot1x     (out_chan.auth_dot1x),
  .psk_offered    (out_chan.psk_offered),
  .declared_length(out_chan.declared_length)
);
`default_nettype wire

/* verif/wie_verdict_checker.sv */
// Verdict checker for the WPA element parser: watches the byte, result and
// register ports, predicts each verdict and compares it. Depends on wie_pkg, wie_if.
`timescale 1ns / 1ps
module wie_verdict_checker
  import wie_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  wie_in_if                     in_mon,
  wie_out_if                    out_mon,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int                    faults,
  output int                    outstanding
);

  localparam logic [23:0] WPA_OUI     = 24'h0050f2;
  localparam int          SUITE_BYTES = 4;
  localparam int          REPORT_MAX  = 10;

  // parser shadow state
  logic [POS_W-1:0]  pos;
  logic [BYTE_W-1:0] ie_len;
  status_t           verdict;
  logic              settled;
  logic [BYTE_W-1:0] lo_hold;
  logic [15:0]       pw_cnt;
  logic [15:0]       akm_cnt;
  logic              oui_ok;
  logic [1:0]        akm_flags;   // [0] 802.1X, [1] PSK
  logic [VER_W-1:0]  ver_limit;

  result_t pending_verdicts[$];

  function automatic void clear_element();
    pos       = '0;
    ie_len    = '0;
    verdict   = ST_OK;
    settled   = 1'b0;
    lo_hold   = '0;
    pw_cnt    = '0;
    akm_cnt   = '0;
    oui_ok    = 1'b1;
    akm_flags = '0;
  endfunction

  function automatic void settle(input status_t s);
    verdict = s;
    settled = 1'b1;
  endfunction

  function automatic void parse_byte(input logic [BYTE_W-1:0] b);
    int          p, len, a, off;
    logic [15:0] word;
    p    = int'(pos);
    len  = int'(ie_len);
    word = {b, lo_hold};
    if (p == POS_EID) begin
      if (b != WPA_EID) settle(ST_BAD_ID);
    end else if (p == POS_LEN) begin
      ie_len = b;
    end else if (p >= POS_OUI0 && p <= POS_OUI2) begin
      off = p - int'(POS_OUI0);
      if (b != WPA_OUI[23 - 8*off -: 8]) oui_ok = 1'b0;
    end else if (p == POS_TYPE) begin
      if (!oui_ok || b != WPA_TYPE) settle(ST_BAD_OUI);
      oui_ok = 1'b1;
    end else if (p == POS_VER_LO || p == POS_PW_LO) begin
      lo_hold = b;
    end else if (p == POS_VER_HI) begin
      if (word > ver_limit) settle(ST_VER_HIGH);
      else if (ie_len <= MIN_LEN) settle(ST_SHORT);
    end else if (p == POS_PW_HI) begin
      pw_cnt = word;
      if (pw_cnt != 0 && len < int'(PW_BASE) + SUITE_BYTES * int'(pw_cnt)) begin
        settle(ST_PW_OVERRUN);
      end else if (len < int'(AKM_BASE) + SUITE_BYTES * int'(pw_cnt)) begin
        // length stops after the pairwise list: AKM list absent, 802.1X assumed
        akm_flags = 2'b01;
        settle(ST_OK);
      end
    end else if (p > POS_PW_HI) begin
      a = int'(AKM_BASE) + SUITE_BYTES * int'(pw_cnt);
      if (p == a) begin
        lo_hold = b;
      end else if (p == a + 1) begin
        akm_cnt = word;
        if (akm_cnt != 0 && len < a + SUITE_BYTES * int'(akm_cnt)) settle(ST_AKM_OVERRUN);
        else if (akm_cnt == 0) settle(ST_OK);
      end else if (p >= a + 2) begin
        off = (p - a - 2) % SUITE_BYTES;
        if (off < 3) begin
          if (b != WPA_OUI[23 - 8*off -: 8]) oui_ok = 1'b0;
        end else begin
          if (oui_ok) begin
            if (b == AKM_DOT1X) akm_flags[0] = 1'b1;
            else if (b == AKM_PSK) akm_flags[1] = 1'b1;
          end
          oui_ok = 1'b1;
          if (p == a + 1 + SUITE_BYTES * int'(akm_cnt)) settle(ST_OK);
        end
      end
    end
  endfunction

  function automatic void absorb_byte(input logic [BYTE_W-1:0] b, input logic last);
    result_t r;
    if (!settled) parse_byte(b);
    if (pos != POS_MAX) pos++;
    if (last) begin
      r.status          = settled ? verdict : ST_TRUNC;
      r.auth_dot1x      = (r.status == ST_OK) ? akm_flags[0] : 1'b0;
      r.psk_offered     = (r.status == ST_OK) ? akm_flags[1] : 1'b0;
      r.declared_length = ie_len;
      pending_verdicts.push_back(r);
      clear_element();
    end
  endfunction

  function automatic void note_fault(input string msg);
    faults++;
    if (faults <= REPORT_MAX) $display("%0t: verdict mismatch: %s", $time, msg);
  endfunction

  always @(posedge clk) begin
    result_t exp;
    if (!rst_n) begin
      clear_element();
      ver_limit = MAX_VERSION_RST;
      pending_verdicts.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == {REG_MAX_VERSION, 2'b00})
        ver_limit = pwdata[VER_W-1:0];
      // compare first so a fresh expectation cannot absorb a stray result
      if (out_mon.valid && out_mon.ready) begin
        if (pending_verdicts.size() == 0) begin
          note_fault($sformatf("unexpected result status %0d dot1x %0b psk %0b len %0d",
                               out_mon.status, out_mon.auth_dot1x, out_mon.psk_offered,
                               out_mon.declared_length));
        end else begin
          exp = pending_verdicts.pop_front();
          if (out_mon.status != exp.status || out_mon.auth_dot1x != exp.auth_dot1x ||
              out_mon.psk_offered != exp.psk_offered ||
              out_mon.declared_length != exp.declared_length)
            note_fault($sformatf({"exp/got status %0d/%0d dot1x %0b/%0b psk %0b/%0b ",
                                  "len %0d/%0d"},
                                 exp.status, out_mon.status, exp.auth_dot1x,
                                 out_mon.auth_dot1x, exp.psk_offered, out_mon.psk_offered,
                                 exp.declared_length, out_mon.declared_length));
        end
      end
      if (in_mon.valid && in_mon.ready) absorb_byte(in_mon.ie_byte, in_mon.last_byte);
    end
    outstanding <= pending_verdicts.size();
  end

endmodule : wie_verdict_checker

/* verif/wpa_ie_auth_type_parser_tb.sv */
// Top of the WPA element parser testbench: clock, reset, byte and result
// traffic, register writes and the verdict. Depends on wie_pkg, wie_if,
// wie_verdict_checker and the parser RTL.
`timescale 1ns / 1ps
module wpa_ie_auth_type_parser_tb;
  import wie_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;  // far above the slowest legal run
  localparam int RANDOM_ITEMS  = 280;     // random bytes after the directed part
  localparam int PHASES        = 5;       // register settings in the random part
  localparam int HOLD_CYCLES   = 300;     // long receiver stall
  localparam int SETTLE_CYCLES = 6;       // lets the pipeline empty after the last verdict
  localparam int LONG_STREAM   = 515;     // past the 511 position saturation
  localparam logic [23:0] WPA_OUI = 24'h0050f2;

  logic clk;
  logic rst_n;

  wie_in_if  in_chan ();
  wie_out_if out_chan ();

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int faults;
  int outstanding;
  int cycle_count;
  int items_sent;

  bit hold_req;             // asks the result side for one long stall
  bit calm;                 // no idling on either side while set
  logic [VER_W-1:0]  cur_max;
  logic [BYTE_W-1:0] elem_q[$];   // bytes of the element being sent

  wpa_ie_auth_type_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  wie_verdict_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .faults      (faults),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Element building. Offsets follow the element layout: ID, length, OUI+type,
  // version, group suite, pairwise count and suites, AKM count and suites.
  // ---------------------------------------------------------------------------
  function automatic void push_word(input logic [15:0] w);
    elem_q.push_back(w[7:0]);
    elem_q.push_back(w[15:8]);
  endfunction

  // a suite under the WPA OUI, or under a random vendor
  function automatic void push_suite(input bit wpa_vendor, input logic [BYTE_W-1:0] kind);
    for (int k = 0; k < 3; k++)
      elem_q.push_back(wpa_vendor ? WPA_OUI[23 - 8*k -: 8] : BYTE_W'($urandom));
    elem_q.push_back(kind);
  endfunction

  // length byte covers everything after itself, clipped to a byte
  function automatic void seal_length();
    elem_q[1] = (elem_q.size() - 2 > 255) ? 8'hff : BYTE_W'(elem_q.size() - 2);
  endfunction

  function automatic void build_wpa_ie(input logic [VER_W-1:0] ver, input int n_pw,
                                       input int n_akm, input bit with_akm);
    logic [BYTE_W-1:0] kind;
    elem_q = {};
    elem_q.push_back(WPA_EID);
    elem_q.push_back(8'h00);
    push_suite(1'b1, WPA_TYPE);
    push_word(ver);
    push_suite(1'b1, BYTE_W'($urandom_range(0, 5)));
    push_word(16'(n_pw));
    repeat (n_pw) push_suite(1'b1, BYTE_W'($urandom_range(0, 5)));
    if (with_akm) begin
      push_word(16'(n_akm));
      repeat (n_akm) begin
        kind = ($urandom_range(0, 2) == 0) ? BYTE_W'($urandom)
                                           : BYTE_W'($urandom_range(1, 2));
        push_suite($urandom_range(0, 3) != 0, kind);
      end
    end
    seal_length();
  endfunction

  // ---------------------------------------------------------------------------
  // Byte source. valid is only lowered for a gap, never in the step where it
  // is raised again, so back-to-back transactions keep it high.
  // ---------------------------------------------------------------------------
  task automatic send_element();
    int gap;
    for (int i = 0; i < elem_q.size(); i++) begin
      gap = (calm || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 17);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_chan.valid     <= 1'b1;
      in_chan.ie_byte   <= elem_q[i];
      in_chan.last_byte <= (i == elem_q.size() - 1);
      @(posedge clk);
      while (!in_chan.ready) @(posedge clk);
      items_sent++;
    end
  endtask

  // drop valid, wait for every verdict, then let the pipeline empty
  task automatic wait_quiet();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_max_version(input logic [VER_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MAX_VERSION, 2'b00};
    pwdata  <= {16'($urandom), v};   // upper bits are not part of the register
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_max = v;
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: random stalls per transaction, plus one long hold on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int gap;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = (calm || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 17);
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int               share, phase_end, kind, n_pw, n_akm, cut;
    bit               with_akm;
    logic [VER_W-1:0] ver, setting;

    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.ie_byte   <= '0;
    in_chan.last_byte <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    hold_req          = 1'b0;
    calm              = 1'b0;
    items_sent        = 0;
    cur_max           = MAX_VERSION_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part, max_version at its reset value of 1 ----
    // wrong element ID on a one-byte element
    elem_q = {8'h00};
    send_element();
    // wrong ID: the length byte that follows is never captured
    elem_q = {8'hff, 8'h12};
    send_element();
    // ends straight after the ID: truncated
    elem_q = {WPA_EID};
    send_element();
    // both WPA key management suites offered
    build_wpa_ie(16'd1, 1, 0, 1'b0);
    push_word(16'd2);
    push_suite(1'b1, AKM_DOT1X);
    push_suite(1'b1, AKM_PSK);
    seal_length();
    send_element();
    // version 0; PSK under a foreign OUI and an unknown WPA suite set no flag
    build_wpa_ie(16'd0, 0, 0, 1'b0);
    push_word(16'd2);
    push_suite(1'b0, AKM_PSK);
    push_suite(1'b1, 8'h07);
    seal_length();
    send_element();
    // bad OUI, then bad type
    build_wpa_ie(16'd1, 0, 1, 1'b1);
    elem_q[3] = 8'h51;
    send_element();
    build_wpa_ie(16'd1, 0, 1, 1'b1);
    elem_q[5] = 8'h02;
    send_element();
    // version above the limit, including the largest version
    build_wpa_ie(16'd2, 0, 1, 1'b1);
    send_element();
    build_wpa_ie(16'hffff, 0, 1, 1'b1);
    send_element();
    // declared length too short, at the boundary and at zero
    build_wpa_ie(16'd1, 0, 1, 1'b1);
    elem_q[1] = MIN_LEN;
    send_element();
    build_wpa_ie(16'd1, 0, 0, 1'b0);
    elem_q[1] = 8'h00;
    send_element();
    // AKM count absent: 802.1X assumed, with and without pairwise suites
    build_wpa_ie(16'd1, 0, 0, 1'b0);
    send_element();
    build_wpa_ie(16'd1, 2, 0, 1'b0);
    send_element();
    // pairwise count far beyond the length
    build_wpa_ie(16'd1, 0, 0, 1'b0);
    elem_q[12] = 8'hff;
    elem_q[13] = 8'hff;
    send_element();
    // AKM count zero: ok with no flags
    build_wpa_ie(16'd1, 1, 0, 1'b1);
    send_element();
    // AKM count high byte pushes the list past the length
    build_wpa_ie(16'd1, 0, 3, 1'b1);
    elem_q[15] = 8'hff;
    send_element();
    // trailing bytes after the verdict are ignored
    build_wpa_ie(16'd1, 0, 1, 1'b1);
    repeat (5) elem_q.push_back(BYTE_W'($urandom));
    send_element();
    // early end inside the pairwise list, length already captured
    build_wpa_ie(16'd1, 1, 2, 1'b1);
    while (elem_q.size() > 17) void'(elem_q.pop_back());
    send_element();
    // longest element the length byte allows
    build_wpa_ie(16'd1, 30, 30, 1'b1);
    elem_q[1] = 8'hff;
    send_element();
    // stream well past position 511
    build_wpa_ie(16'd1, 0, 0, 1'b0);
    while (elem_q.size() < LONG_STREAM) elem_q.push_back(BYTE_W'($urandom));
    send_element();

    // ---- random part, one register setting per phase ----
    share = RANDOM_ITEMS / PHASES;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       setting = 16'h0000;
        1:       setting = 16'hffff;
        2:       setting = 16'h0002;
        3:       setting = VER_W'($urandom);
        default: setting = MAX_VERSION_RST;
      endcase
      wait_quiet();
      write_max_version(setting);
      phase_end = items_sent + share;

      // receiver stalls for a long stretch while short elements pile up
      if (ph == 2) begin
        hold_req = 1'b1;
        calm     = 1'b1;
        repeat (30) begin
          elem_q = {WPA_EID, BYTE_W'($urandom)};
          send_element();
        end
      end

      while (items_sent < phase_end) begin
        calm = ($urandom_range(0, 4) == 0);
        case ($urandom_range(0, 3))
          0:       ver = cur_max;
          1:       ver = cur_max + 1'b1;
          2:       ver = '0;
          default: ver = VER_W'($urandom);
        endcase
        n_pw     = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 20) : $urandom_range(0, 1);
        n_akm    = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 20) : $urandom_range(0, 2);
        with_akm = ($urandom_range(0, 5) != 0);
        build_wpa_ie(ver, n_pw, n_akm, with_akm);
        kind = $urandom_range(0, 9);
        case (kind)
          4: begin   // cut short anywhere
            cut = $urandom_range(1, elem_q.size());
            while (elem_q.size() > cut) void'(elem_q.pop_back());
          end
          5: elem_q[$urandom_range(0, elem_q.size() - 1)] = BYTE_W'($urandom);
          6: elem_q[1] = BYTE_W'($urandom);
          7: repeat ($urandom_range(1, 8)) elem_q.push_back(BYTE_W'($urandom));
          8: elem_q[$urandom_range(12, 13)] = BYTE_W'($urandom);
          9: begin   // noise: a few random bytes
            elem_q = {};
            repeat ($urandom_range(1, 4)) elem_q.push_back(BYTE_W'($urandom));
          end
          default: ;  // well-formed
        endcase
        send_element();
      end
    end

    calm = 1'b0;
    wait_quiet();
    if (faults == 0 && outstanding == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule : wpa_ie_auth_type_parser_tb

/* filelist.f */
rtl/wie_pkg.sv
rtl/wie_if.sv
rtl/wie_cfg_regs.sv
rtl/wie_in_stage.sv
rtl/wie_parse_core.sv
rtl/wie_out_stage.sv
rtl/wpa_ie_auth_type_parser.sv
rtl/wie_checker.sv
verif/wie_verdict_checker.sv
verif/wpa_ie_auth_type_parser_tb.sv
